FILE: rtl/qat_pkg.sv
`default_nettype none

package qat_pkg;

    localparam int DEFAULT_MAX_DELIMS = 4;
    localparam int MAX_RES            = 4;

    localparam logic [31:0] DELIM_CHARS_RST = 32'h0000_0900;
    localparam logic [2:0]  DELIM_COUNT_RST = 3'd2;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_NL     = 8'h0A;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_EOL  = 2'd2
    } t_kind;

    typedef enum logic {
        REG_DELIM_CHARS = 1'b0,
        REG_DELIM_COUNT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_res;

    typedef struct packed {
        t_res [MAX_RES-1:0] res;
        logic [2:0]         count;
    } t_burst;

    function automatic t_burst push(input t_burst b, input t_kind k, input logic [7:0] d);
        t_burst r;
        r = b;
        if (r.count < 3'(MAX_RES)) begin
            r.res[r.count[1:0]].kind = k;
            r.res[r.count[1:0]].data = (k == KIND_BYTE) ? d : 8'd0;
            r.count = r.count + 3'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/quoted_argument_tokenizer_core.sv
`default_nettype none

// Splits a command line, one byte per request, into argument bytes, token-end
// marks and an end-of-line mark. Each accepted byte passes an input register and
// is decoded combinationally into up to four results, handed out one per cycle by
// an output buffer while the receiver is ready. A new byte is taken every cycle
// while each yields at most one result and the receiver is ready; the input stalls
// until a byte's last result is taken. The user sets delimiter bytes and count
// at APB addresses 0x0 and 0x4 only while idle; the block does not enforce this.
module quoted_argument_tokenizer_core
    import qat_pkg::*;
#(
    parameter int MAX_DELIMS = DEFAULT_MAX_DELIMS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_last,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_out_kind,
    output logic [7:0]       o_out_byte,
    output logic             o_run_last
);

    logic [31:0] r_delim_chars;
    logic [2:0]  r_delim_count;
    t_reg_idx    reg_idx;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_idx)
            REG_DELIM_CHARS: prdata = r_delim_chars;
            REG_DELIM_COUNT: prdata = {29'd0, r_delim_count};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim_chars <= DELIM_CHARS_RST;
            r_delim_count <= DELIM_COUNT_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_DELIM_CHARS: r_delim_chars <= pwdata;
                REG_DELIM_COUNT: r_delim_count <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       obuf_free;
    logic       adv;
    t_burst     burst;

    assign adv        = r_in_vld && obuf_free;
    assign o_in_ready = !r_in_vld || obuf_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
    end

    qat_step #(
        .MAX_DELIMS(MAX_DELIMS)
    ) u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_byte        (r_in_byte),
        .i_last        (r_in_last),
        .i_delim_chars (r_delim_chars),
        .i_delim_count (r_delim_count),
        .o_burst       (burst)
    );

    qat_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (adv),
        .i_burst    (burst),
        .o_free     (obuf_free),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_kind     (o_out_kind),
        .o_byte     (o_out_byte),
        .o_run_last (o_run_last)
    );

endmodule

`default_nettype wire

FILE: rtl/qat_step.sv
`default_nettype none

module qat_step
    import qat_pkg::*;
#(
    parameter int MAX_DELIMS = DEFAULT_MAX_DELIMS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_adv,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_last,
    input  wire logic [31:0] i_delim_chars,
    input  wire logic [2:0]  i_delim_count,
    output t_burst           o_burst
);

    localparam logic [3:0] MaxCnt = 4'(MAX_DELIMS);

    logic r_in_word, r_in_quotes, r_quote_pending, r_held_bslash, r_prev_bslash;
    logic n_in_word, n_in_quotes, n_quote_pending, n_held_bslash, n_prev_bslash;

    logic [3:0] eff_count;
    logic       is_delim;

    always_comb begin
        eff_count = ({1'b0, i_delim_count} > MaxCnt) ? MaxCnt : {1'b0, i_delim_count};
        is_delim  = 1'b0;
        for (int k = 0; k < MAX_DELIMS; k++) begin
            if ((4'(k) < eff_count) && (8'(i_delim_chars >> (8 * k)) == i_byte)) begin
                is_delim = 1'b1;
            end
        end
    end

    logic quote_hit, delim_hit, tend_a, tbyte;
    t_burst b;

    always_comb begin
        n_in_word       = r_in_word;
        n_in_quotes     = r_in_quotes;
        n_quote_pending = r_quote_pending;
        n_held_bslash   = r_held_bslash;
        b               = '0;

        if (r_quote_pending) begin
            n_quote_pending = 1'b0;
            if (i_byte != CH_QUOTE && i_byte != CH_NL) begin
                n_in_quotes = 1'b1;
            end
        end

        quote_hit = (i_byte == CH_QUOTE) && !r_prev_bslash;
        delim_hit = !quote_hit && !n_in_quotes && is_delim;
        tend_a    = (quote_hit && (n_in_word || n_in_quotes)) || (delim_hit && n_in_word);
        tbyte     = !quote_hit && !delim_hit;

        if (tend_a) begin
            if (n_held_bslash) begin
                b = push(b, KIND_BYTE, CH_BSLASH);
                n_held_bslash = 1'b0;
            end
            b = push(b, KIND_END, 8'd0);
        end

        if (quote_hit) begin
            n_in_word = 1'b0;
            if (n_in_quotes) begin
                n_in_quotes = 1'b0;
            end else if (!i_last) begin
                n_quote_pending = 1'b1;
            end
        end
        if (delim_hit) begin
            n_in_word = 1'b0;
        end

        if (tbyte) begin
            if (!n_in_quotes) begin
                n_in_word = 1'b1;
            end
            if (n_held_bslash && i_byte == CH_QUOTE) begin
                b = push(b, KIND_BYTE, CH_QUOTE);
                n_held_bslash = 1'b0;
            end else begin
                if (n_held_bslash) begin
                    b = push(b, KIND_BYTE, CH_BSLASH);
                    n_held_bslash = 1'b0;
                end
                if (i_byte == CH_BSLASH) begin
                    n_held_bslash = 1'b1;
                end else begin
                    b = push(b, KIND_BYTE, i_byte);
                end
            end
        end

        n_prev_bslash = (i_byte == CH_BSLASH);

        if (i_last) begin
            if (n_in_word || n_in_quotes) begin
                if (n_held_bslash) begin
                    b = push(b, KIND_BYTE, CH_BSLASH);
                end
                b = push(b, KIND_END, 8'd0);
            end
            b = push(b, KIND_EOL, 8'd0);
            n_held_bslash   = 1'b0;
            n_in_word       = 1'b0;
            n_in_quotes     = 1'b0;
            n_quote_pending = 1'b0;
            n_prev_bslash   = 1'b0;
        end

        o_burst = b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_word       <= 1'b0;
            r_in_quotes     <= 1'b0;
            r_quote_pending <= 1'b0;
            r_held_bslash   <= 1'b0;
            r_prev_bslash   <= 1'b0;
        end else if (i_adv) begin
            r_in_word       <= n_in_word;
            r_in_quotes     <= n_in_quotes;
            r_quote_pending <= n_quote_pending;
            r_held_bslash   <= n_held_bslash;
            r_prev_bslash   <= n_prev_bslash;
        end
    end

`ifndef SYNTHESIS
    a_word_quote_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_in_word && r_in_quotes))
        else $error("word and quoted argument open together");

    a_pending_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_quote_pending |-> (!r_in_quotes && !r_in_word))
        else $error("quote pending while a token is open");

    a_bslash_in_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_bslash |-> (r_in_word || r_in_quotes))
        else $error("backslash held outside a token");
`endif

endmodule

`default_nettype wire

FILE: rtl/qat_obuf.sv
`default_nettype none

module qat_obuf
    import qat_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire t_burst     i_burst,
    output logic            o_free,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_byte,
    output logic            o_run_last
);

    logic       r_vld;
    t_burst     r_burst;
    logic [1:0] r_idx;

    assign o_valid    = r_vld;
    assign o_kind     = r_burst.res[r_idx].kind;
    assign o_byte     = r_burst.res[r_idx].data;
    assign o_run_last = ({1'b0, r_idx} == (r_burst.count - 3'd1));
    assign o_free     = !r_vld || (i_ready && o_run_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_idx <= 2'd0;
        end else if (i_load) begin
            r_vld <= (i_burst.count != 3'd0);
            r_idx <= 2'd0;
        end else if (r_vld && i_ready) begin
            if (o_run_last) begin
                r_vld <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_burst <= i_burst;
        end
    end

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> ({1'b0, r_idx} < r_burst.count))
        else $error("result index beyond burst");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("burst loaded over pending results");

    a_empty_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && i_burst.count == 3'd0) |=> !r_vld)
        else $error("empty burst shown as valid");
`endif

endmodule

`default_nettype wire
